### rtl/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  // Field widths
  localparam int unsigned HUE_W  = 9;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned DEG_W  = 6;   // hue offset inside a sector, 0..59
  localparam int unsigned LVL_W  = 15;  // brightness*255, 0..25500
  localparam int unsigned COEF_W = 13;  // sector coefficients, 0..6000
  localparam int unsigned PROD_W = LVL_W + COEF_W;

  // Range limits and fixed coefficients
  localparam logic [HUE_W-1:0]  HUE_MAX  = 9'd360;
  localparam logic [PCT_W-1:0]  PCT_MAX  = 7'd100;
  localparam logic [COEF_W-1:0] COEF_TOP = 13'd6000;

  // Hue sector; hue of exactly 360 is folded into SEC_5 with zero offset
  typedef enum logic [2:0] {
    SEC_0,
    SEC_1,
    SEC_2,
    SEC_3,
    SEC_4,
    SEC_5
  } sector_t;

  // Per-stage load enables handed to a datapath module (two stages each)
  typedef struct packed {
    logic first;
    logic second;
  } stage_en_t;

  // Stage 2 result: sector, level and the three variable coefficients (top is fixed)
  typedef struct packed {
    sector_t            sector;
    logic [LVL_W-1:0]   lvl;
    logic [COEF_W-1:0]  k_bot;
    logic [COEF_W-1:0]  k_up;
    logic [COEF_W-1:0]  k_dn;
  } coef_t;

  // Stage 4 result: the four candidate channel values
  typedef struct packed {
    sector_t          sector;
    logic [CH_W-1:0]  q_top;
    logic [CH_W-1:0]  q_bot;
    logic [CH_W-1:0]  q_up;
    logic [CH_W-1:0]  q_dn;
  } level_t;

endpackage

### rtl/hsv2rgb_prep.sv
// Stages 1 and 2: clamp, sector split, level and coefficient setup.
// All channel values are lvl*k/600000 with lvl = v*255:
//   top k = 6000, bottom k = 60*(100-s), up k = bottom + s*d, down k = 6000 - s*d
module hsv2rgb_prep (
  input  logic                                clk,
  input  hsv2rgb_pkg::stage_en_t              en,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]       hue,
  input  logic [hsv2rgb_pkg::PCT_W-1:0]       saturation,
  input  logic [hsv2rgb_pkg::PCT_W-1:0]       brightness,
  output hsv2rgb_pkg::coef_t                  coef
);

  localparam int unsigned COEF_W = hsv2rgb_pkg::COEF_W;

  logic [hsv2rgb_pkg::HUE_W-1:0]  h_c;
  logic [hsv2rgb_pkg::PCT_W-1:0]  s_c;
  logic [hsv2rgb_pkg::PCT_W-1:0]  v_c;
  logic [hsv2rgb_pkg::HUE_W-1:0]  h_off;
  hsv2rgb_pkg::sector_t           sec_nxt;
  logic [hsv2rgb_pkg::LVL_W-1:0]  lvl_nxt;

  hsv2rgb_pkg::sector_t           sec1_r;
  logic [hsv2rgb_pkg::DEG_W-1:0]  deg1_r;
  logic [hsv2rgb_pkg::PCT_W-1:0]  sat1_r;
  logic [hsv2rgb_pkg::LVL_W-1:0]  lvl1_r;

  logic [hsv2rgb_pkg::COEF_W-1:0] s60;
  logic [hsv2rgb_pkg::COEF_W-1:0] sd;
  hsv2rgb_pkg::coef_t             coef_nxt;
  hsv2rgb_pkg::coef_t             coef_r;

  // Stage 1: clamp and split hue into sector and offset
  always_comb begin
    h_c = (hue > hsv2rgb_pkg::HUE_MAX) ? hsv2rgb_pkg::HUE_MAX : hue;
    s_c = (saturation > hsv2rgb_pkg::PCT_MAX) ? hsv2rgb_pkg::PCT_MAX : saturation;
    v_c = (brightness > hsv2rgb_pkg::PCT_MAX) ? hsv2rgb_pkg::PCT_MAX : brightness;
    if (h_c == hsv2rgb_pkg::HUE_MAX) begin
      sec_nxt = hsv2rgb_pkg::SEC_5;
      h_off   = '0;
    end else if (h_c >= 9'd300) begin
      sec_nxt = hsv2rgb_pkg::SEC_5;
      h_off   = h_c - 9'd300;
    end else if (h_c >= 9'd240) begin
      sec_nxt = hsv2rgb_pkg::SEC_4;
      h_off   = h_c - 9'd240;
    end else if (h_c >= 9'd180) begin
      sec_nxt = hsv2rgb_pkg::SEC_3;
      h_off   = h_c - 9'd180;
    end else if (h_c >= 9'd120) begin
      sec_nxt = hsv2rgb_pkg::SEC_2;
      h_off   = h_c - 9'd120;
    end else if (h_c >= 9'd60) begin
      sec_nxt = hsv2rgb_pkg::SEC_1;
      h_off   = h_c - 9'd60;
    end else begin
      sec_nxt = hsv2rgb_pkg::SEC_0;
      h_off   = h_c;
    end
    // v*255 = v*256 - v
    lvl_nxt = {v_c, 8'd0} - {8'd0, v_c};
  end

  always_ff @(posedge clk) begin
    if (en.first) begin
      sec1_r <= sec_nxt;
      deg1_r <= h_off[hsv2rgb_pkg::DEG_W-1:0];
      sat1_r <= s_c;
      lvl1_r <= lvl_nxt;
    end
  end

  // Stage 2: sector coefficients
  always_comb begin
    s60 = {sat1_r, 6'd0} - {4'd0, sat1_r, 2'd0};
    sd  = COEF_W'(sat1_r) * COEF_W'(deg1_r);
    coef_nxt.sector = sec1_r;
    coef_nxt.lvl    = lvl1_r;
    coef_nxt.k_bot  = hsv2rgb_pkg::COEF_TOP - s60;
    coef_nxt.k_up   = hsv2rgb_pkg::COEF_TOP - s60 + sd;
    coef_nxt.k_dn   = hsv2rgb_pkg::COEF_TOP - sd;
  end

  always_ff @(posedge clk) begin
    if (en.second) begin
      coef_r <= coef_nxt;
    end
  end

  assign coef = coef_r;

endmodule

### rtl/hsv2rgb_scale.sv
// Stages 3 and 4: lvl*k products, then divide each by 600000.
// n/600000 = (n>>6)/9375; the divide by 9375 is a reciprocal multiply
// exact for every 22-bit dividend (M = ceil(2^36/9375)).
module hsv2rgb_scale (
  input  logic                    clk,
  input  hsv2rgb_pkg::stage_en_t  en,
  input  hsv2rgb_pkg::coef_t      coef,
  output hsv2rgb_pkg::level_t     level
);

  localparam int unsigned PROD_W  = hsv2rgb_pkg::PROD_W;
  localparam int unsigned CH_W    = hsv2rgb_pkg::CH_W;
  localparam int unsigned DIV_W   = PROD_W - 6;
  localparam int unsigned RECIP_W = 23;
  localparam int unsigned RECIP_SH = 36;
  localparam logic [RECIP_W-1:0] RECIP_M = 23'd7330078;

  function automatic logic [CH_W-1:0] div_600k(input logic [PROD_W-1:0] n);
    logic [DIV_W+RECIP_W-1:0] p;
    p = (DIV_W+RECIP_W)'(n[PROD_W-1:6]) * (DIV_W+RECIP_W)'(RECIP_M);
    return p[RECIP_SH+CH_W-1:RECIP_SH];
  endfunction

  hsv2rgb_pkg::sector_t  sec3_r;
  logic [PROD_W-1:0]     p_top_r;
  logic [PROD_W-1:0]     p_bot_r;
  logic [PROD_W-1:0]     p_up_r;
  logic [PROD_W-1:0]     p_dn_r;
  hsv2rgb_pkg::level_t   level_nxt;
  hsv2rgb_pkg::level_t   level_r;

  // Stage 3: four parallel products
  always_ff @(posedge clk) begin
    if (en.first) begin
      sec3_r  <= coef.sector;
      p_top_r <= PROD_W'(coef.lvl) * PROD_W'(hsv2rgb_pkg::COEF_TOP);
      p_bot_r <= PROD_W'(coef.lvl) * PROD_W'(coef.k_bot);
      p_up_r  <= PROD_W'(coef.lvl) * PROD_W'(coef.k_up);
      p_dn_r  <= PROD_W'(coef.lvl) * PROD_W'(coef.k_dn);
    end
  end

  // Stage 4: truncating divide of each product
  always_comb begin
    level_nxt.sector = sec3_r;
    level_nxt.q_top  = div_600k(p_top_r);
    level_nxt.q_bot  = div_600k(p_bot_r);
    level_nxt.q_up   = div_600k(p_up_r);
    level_nxt.q_dn   = div_600k(p_dn_r);
  end

  always_ff @(posedge clk) begin
    if (en.second) begin
      level_r <= level_nxt;
    end
  end

  assign level = level_r;

endmodule

### rtl/hsv_to_rgb_converter_unit.sv
// Channel  Dir  Beat fields (tdata, low bit up)
// in_      in   hue[8:0], saturation[15:9], brightness[22:16], zero[23]
// out_     out  red[7:0], green[15:8], blue[23:16]
//
// One color per clock sustained while the output is not stalled; input beats pass
// through clamp/sector, coefficients, products, divide and select to the output register.
// Each stage holds a valid bit and loads when it is empty or its successor
// moves, so bubbles close up under an output stall and nothing is dropped.
// Synchronous active-low reset clears the valid bits only.
module hsv_to_rgb_converter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // hue[8:0], saturation[15:9], brightness[22:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // red[7:0], green[15:8], blue[23:16]
);

  logic vld1_r, vld2_r, vld3_r, vld4_r, out_valid_r;
  logic ld1, ld2, ld3, ld4, ld_out;

  hsv2rgb_pkg::stage_en_t prep_en;
  hsv2rgb_pkg::stage_en_t scale_en;
  hsv2rgb_pkg::coef_t     coef;
  hsv2rgb_pkg::level_t    level;

  logic [hsv2rgb_pkg::CH_W-1:0] red_nxt, green_nxt, blue_nxt;
  logic [23:0]                  out_data_r;

  // Stage load enables, back to front
  always_comb begin
    ld_out = !out_valid_r || out_tready;
    ld4    = !vld4_r || ld_out;
    ld3    = !vld3_r || ld4;
    ld2    = !vld2_r || ld3;
    ld1    = !vld1_r || ld2;
    prep_en.first   = ld1;
    prep_en.second  = ld2;
    scale_en.first  = ld3;
    scale_en.second = ld4;
  end

  assign in_tready = ld1;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r      <= 1'b0;
      vld2_r      <= 1'b0;
      vld3_r      <= 1'b0;
      vld4_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1)    vld1_r      <= in_tvalid;
      if (ld2)    vld2_r      <= vld1_r;
      if (ld3)    vld3_r      <= vld2_r;
      if (ld4)    vld4_r      <= vld3_r;
      if (ld_out) out_valid_r <= vld4_r;
    end
  end

  hsv2rgb_prep u_prep (
    .clk        (clk),
    .en         (prep_en),
    .hue        (in_tdata[8:0]),
    .saturation (in_tdata[15:9]),
    .brightness (in_tdata[22:16]),
    .coef       (coef)
  );

  hsv2rgb_scale u_scale (
    .clk   (clk),
    .en    (scale_en),
    .coef  (coef),
    .level (level)
  );

  // Stage 5: route levels to channels by sector
  always_comb begin
    case (level.sector)
      hsv2rgb_pkg::SEC_0: begin
        red_nxt = level.q_top; green_nxt = level.q_up;  blue_nxt = level.q_bot;
      end
      hsv2rgb_pkg::SEC_1: begin
        red_nxt = level.q_dn;  green_nxt = level.q_top; blue_nxt = level.q_bot;
      end
      hsv2rgb_pkg::SEC_2: begin
        red_nxt = level.q_bot; green_nxt = level.q_top; blue_nxt = level.q_up;
      end
      hsv2rgb_pkg::SEC_3: begin
        red_nxt = level.q_bot; green_nxt = level.q_dn;  blue_nxt = level.q_top;
      end
      hsv2rgb_pkg::SEC_4: begin
        red_nxt = level.q_up;  green_nxt = level.q_bot; blue_nxt = level.q_top;
      end
      default: begin
        red_nxt = level.q_top; green_nxt = level.q_bot; blue_nxt = level.q_dn;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_data_r <= {blue_nxt, green_nxt, red_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  // accepted beat lands in stage 1
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld1_r)
    else $error("accepted beat missing from stage 1");

  // last stage holds its item while the output register is blocked
  a_hold4: assert property (@(posedge clk) disable iff (!rst_n)
    vld4_r && !ld_out |=> vld4_r && $stable(level))
    else $error("stage 4 item lost under stall");

  // after a taken result, the output valid bit matches what stage 4 offered
  a_refill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tready |=> out_valid_r == $past(vld4_r))
    else $error("output refill mismatch");

  // empty output register never back-pressures the input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output");
`endif

endmodule
